// File: sv/cibf_pkg.sv
// Shared types, constants and signature tables for the image boundary finder.
// No dependencies.
`default_nettype none

package cibf_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int INDEX_BITS  = 16;
    localparam int OUT_OFFSET_BITS = 32;
    localparam int OUT_INDEX_BITS  = 16;

    localparam logic [7:0] MK_FF    = 8'hFF;
    localparam logic [7:0] MK_SOI   = 8'hD8;
    localparam logic [7:0] MK_EOI   = 8'hD9;
    localparam logic [7:0] MK_SOS   = 8'hDA;
    localparam logic [7:0] MK_TEM   = 8'h01;
    localparam logic [7:0] MK_STUFF = 8'h00;
    localparam logic [4:0] MK_RST_HI = 5'b11010;   // D0..D7

    typedef enum logic [11:0] {
        PH_SIG      = 12'b0000_0000_0001,
        PH_TRAIL    = 12'b0000_0000_0010,
        PH_DEAD     = 12'b0000_0000_0100,
        PH_J_MARK   = 12'b0000_0000_1000,
        PH_J_CODE   = 12'b0000_0001_0000,
        PH_J_LEN_HI = 12'b0000_0010_0000,
        PH_J_LEN_LO = 12'b0000_0100_0000,
        PH_J_SKIP   = 12'b0000_1000_0000,
        PH_J_SCAN   = 12'b0001_0000_0000,
        PH_P_LEN    = 12'b0010_0000_0000,
        PH_P_TYPE   = 12'b0100_0000_0000,
        PH_P_SKIP   = 12'b1000_0000_0000
    } phase_t;

    typedef enum logic [1:0] {
        FMT_JPEG  = 2'd0,
        FMT_PNG   = 2'd1,
        FMT_OTHER = 2'd2
    } fmt_t;

    typedef enum logic [2:0] {
        ST_ENDED      = 3'd0,
        ST_ENDED_LAST = 3'd1,
        ST_TRAILING   = 3'd2,
        ST_UNRECOG    = 3'd3,
        ST_BAD_MARKER = 3'd4,
        ST_TRUNCATED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_END  = 2'd1,
        EV_BAD  = 2'd2
    } event_t;

    function automatic logic [7:0] png_sig_byte(input logic [2:0] k);
        logic [7:0] v;
        case (k)
            3'd0:    v = 8'h89;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4E;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0D;
            3'd5:    v = 8'h0A;
            3'd6:    v = 8'h1A;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] iend_byte(input logic [1:0] k);
        logic [7:0] v;
        case (k)
            2'd0:    v = 8'h49;
            2'd1:    v = 8'h45;
            2'd2:    v = 8'h4E;
            default: v = 8'h44;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/concatenated_image_boundary_finder.sv
// Image boundary finder: splits a byte stream of JPEG/PNG images laid end to end.
// Top level, single module. Depends on cibf_pkg.
//
// Usage:
//   Byte channel (byte_valid / byte_stall, data_byte, end_of_stream) takes one
//   byte of the stream per item; end_of_stream marks the last byte, after
//   which all parser state returns to its reset value and a new stream may start.
//   Piece channel (piece_valid / piece_stall, start_offset, end_offset,
//   piece_format, piece_index, status) gives at most one item per byte: an
//   image end, a bad marker, a truncation, trailing or unrecognized data.
//   Throughput: one byte per cycle. Each byte is handled by one pass of the
//   parser logic into the state registers; the result register is loaded at
//   the same edge, so a piece item is valid the cycle after its byte.
//   When the receiver stalls with a piece item held, byte_stall rises and no
//   byte is taken until that item leaves; an empty or draining result
//   register lets bytes flow every cycle.
//   Reset (rst_n low, asynchronous) clears the parser to signature matching,
//   offsets and piece count to zero, and empties the result register.
`default_nettype none

module concatenated_image_boundary_finder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_stream,
    output logic             piece_valid,
    input  wire logic        piece_stall,
    output logic [31:0]      start_offset,
    output logic [31:0]      end_offset,
    output logic [1:0]       piece_format,
    output logic [15:0]      piece_index,
    output logic [2:0]       status
);
    import cibf_pkg::*;

    phase_t                  phase_reg,  phase_next;
    logic [OFFSET_BITS-1:0]  offset_reg, offset_next;
    logic [OFFSET_BITS-1:0]  pstart_reg, pstart_next;
    logic [2:0]              sigcnt_reg, sigcnt_next;
    logic                    jcand_reg,  jcand_next;
    logic                    pcand_reg,  pcand_next;
    logic [31:0]             acc_reg,    acc_next;
    logic [32:0]             skip_reg,   skip_next;
    logic                    cie_reg,    cie_next;
    logic                    sawff_reg,  sawff_next;
    logic [INDEX_BITS-1:0]   count_reg,  count_next;

    logic                    pvalid_reg, pvalid_next;
    logic [OFFSET_BITS-1:0]  ostart_reg, oend_reg;
    fmt_t                    ofmt_reg;
    logic [INDEX_BITS-1:0]   oindex_reg;
    status_t                 ostatus_reg;

    logic                    accept;
    logic                    emit;
    fmt_t                    emit_fmt;
    status_t                 emit_status;

    logic [OFFSET_BITS+OUT_OFFSET_BITS-1:0] start_ext, end_ext;
    logic [INDEX_BITS+OUT_INDEX_BITS-1:0]   index_ext;

    assign byte_stall = pvalid_reg && piece_stall;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        event_t     ev;
        logic       do_code;
        logic       seg_done;
        logic       is_png;
        logic       jc;
        logic       pc;
        logic [2:0] k;
        logic [15:0] seg_len;
        logic [32:0] skip_dec;

        phase_next  = phase_reg;
        offset_next = offset_reg;
        pstart_next = pstart_reg;
        sigcnt_next = sigcnt_reg;
        jcand_next  = jcand_reg;
        pcand_next  = pcand_reg;
        acc_next    = acc_reg;
        skip_next   = skip_reg;
        cie_next    = cie_reg;
        sawff_next  = sawff_reg;
        count_next  = count_reg;
        emit        = 1'b0;
        emit_fmt    = FMT_JPEG;
        emit_status = ST_ENDED;

        ev       = EV_NONE;
        do_code  = 1'b0;
        seg_done = 1'b0;
        is_png   = (phase_reg == PH_P_LEN) || (phase_reg == PH_P_TYPE)
                || (phase_reg == PH_P_SKIP);
        k        = sigcnt_reg;
        jc       = 1'b0;
        pc       = 1'b0;
        seg_len  = {acc_reg[7:0], data_byte};
        skip_dec = (skip_reg != 33'd0) ? skip_reg - 33'd1 : skip_reg;

        case (phase_reg)
            PH_SIG:
            begin
                jc = jcand_reg && (k < 3'd2)
                     && (data_byte == (k[0] ? MK_SOI : MK_FF));
                pc = pcand_reg && (data_byte == png_sig_byte(k));
                jcand_next  = jc;
                pcand_next  = pc;
                sigcnt_next = k + 3'd1;
                if (jc && k == 3'd1)
                begin
                    phase_next = PH_J_MARK;
                end
                else if (pc && k == 3'd7)
                begin
                    phase_next  = PH_P_LEN;
                    sigcnt_next = 3'd0;
                    acc_next    = 32'd0;
                end
                else if (!jc && !pc)
                begin
                    phase_next = PH_TRAIL;
                end
            end
            PH_J_MARK:
            begin
                if (data_byte == MK_FF)
                    phase_next = PH_J_CODE;
                else
                    ev = EV_BAD;
            end
            PH_J_CODE:
            begin
                do_code = 1'b1;
            end
            PH_J_LEN_HI:
            begin
                acc_next   = {24'd0, data_byte};
                phase_next = PH_J_LEN_LO;
            end
            PH_J_LEN_LO:
            begin
                if (seg_len < 16'd2)
                begin
                    ev = EV_BAD;
                end
                else
                begin
                    skip_next = {17'd0, seg_len - 16'd2};
                    if (seg_len == 16'd2)
                        seg_done = 1'b1;
                    else
                        phase_next = PH_J_SKIP;
                end
            end
            PH_J_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 33'd0)
                    seg_done = 1'b1;
            end
            PH_J_SCAN:
            begin
                if (!sawff_reg)
                begin
                    if (data_byte == MK_FF)
                        sawff_next = 1'b1;
                end
                else if (data_byte == MK_FF)
                begin
                    sawff_next = 1'b1;   // fill byte
                end
                else if (data_byte == MK_STUFF || data_byte[7:3] == MK_RST_HI)
                begin
                    sawff_next = 1'b0;
                end
                else
                begin
                    sawff_next = 1'b0;
                    do_code    = 1'b1;
                end
            end
            PH_P_LEN:
            begin
                acc_next    = {acc_reg[23:0], data_byte};
                sigcnt_next = sigcnt_reg + 3'd1;
                if (sigcnt_reg == 3'd3)
                begin
                    phase_next  = PH_P_TYPE;
                    sigcnt_next = 3'd0;
                    cie_next    = 1'b1;
                end
            end
            PH_P_TYPE:
            begin
                cie_next    = cie_reg && (data_byte == iend_byte(k[1:0]));
                sigcnt_next = {1'b0, k[1:0]} + 3'd1;
                if (k[1:0] == 2'd3)
                begin
                    skip_next  = {1'b0, acc_reg} + 33'd4;   // data plus CRC
                    phase_next = PH_P_SKIP;
                end
            end
            PH_P_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 33'd0)
                begin
                    if (cie_reg)
                    begin
                        ev = EV_END;
                    end
                    else
                    begin
                        phase_next  = PH_P_LEN;
                        sigcnt_next = 3'd0;
                        acc_next    = 32'd0;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;   // trailing data or dead: hold
            end
        endcase

        // Segment skipped: SOS enters entropy data, anything else a new marker.
        if (seg_done)
        begin
            if (cie_reg)
            begin
                phase_next = PH_J_SCAN;
                sawff_next = 1'b0;
            end
            else
            begin
                phase_next = PH_J_MARK;
            end
        end

        // Marker code after FF.
        if (do_code)
        begin
            if (data_byte == MK_FF)
                phase_next = PH_J_CODE;
            else if (data_byte == MK_EOI)
                ev = EV_END;
            else if (data_byte == MK_STUFF || data_byte == MK_SOI)
                ev = EV_BAD;
            else if (data_byte == MK_TEM || data_byte[7:3] == MK_RST_HI)
                phase_next = PH_J_MARK;
            else
            begin
                cie_next   = (data_byte == MK_SOS);
                phase_next = PH_J_LEN_HI;
            end
        end

        case (ev)
            EV_END:
            begin
                emit        = 1'b1;
                emit_fmt    = is_png ? FMT_PNG : FMT_JPEG;
                emit_status = end_of_stream ? ST_ENDED_LAST : ST_ENDED;
                if (count_reg != {INDEX_BITS{1'b1}})
                    count_next = count_reg + 1'b1;
                pstart_next = offset_reg + 1'b1;
                phase_next  = PH_SIG;
                sigcnt_next = 3'd0;
                jcand_next  = 1'b1;
                pcand_next  = 1'b1;
                cie_next    = 1'b0;
                sawff_next  = 1'b0;
            end
            EV_BAD:
            begin
                emit        = 1'b1;
                emit_fmt    = is_png ? FMT_PNG : FMT_JPEG;
                emit_status = ST_BAD_MARKER;
                phase_next  = PH_DEAD;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (end_of_stream)
        begin
            if (!emit)
            begin
                if (phase_next == PH_SIG || phase_next == PH_TRAIL)
                begin
                    emit        = 1'b1;
                    emit_fmt    = FMT_OTHER;
                    emit_status = (count_reg == '0) ? ST_UNRECOG : ST_TRAILING;
                end
                else if (phase_next != PH_DEAD)
                begin
                    emit        = 1'b1;
                    emit_fmt    = ((phase_next == PH_P_LEN) || (phase_next == PH_P_TYPE)
                                   || (phase_next == PH_P_SKIP)) ? FMT_PNG : FMT_JPEG;
                    emit_status = ST_TRUNCATED;
                end
            end
            phase_next  = PH_SIG;
            offset_next = '0;
            pstart_next = '0;
            sigcnt_next = 3'd0;
            jcand_next  = 1'b1;
            pcand_next  = 1'b1;
            acc_next    = 32'd0;
            skip_next   = 33'd0;
            cie_next    = 1'b0;
            sawff_next  = 1'b0;
            count_next  = '0;
        end
        else
        begin
            offset_next = offset_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (accept && emit)
            pvalid_next = 1'b1;
        else if (!piece_stall)
            pvalid_next = 1'b0;
        else
            pvalid_next = pvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            offset_reg <= '0;
            pstart_reg <= '0;
            sigcnt_reg <= 3'd0;
            jcand_reg  <= 1'b1;
            pcand_reg  <= 1'b1;
            acc_reg    <= 32'd0;
            skip_reg   <= 33'd0;
            cie_reg    <= 1'b0;
            sawff_reg  <= 1'b0;
            count_reg  <= '0;
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= pvalid_next;
            if (accept)
            begin
                phase_reg  <= phase_next;
                offset_reg <= offset_next;
                pstart_reg <= pstart_next;
                sigcnt_reg <= sigcnt_next;
                jcand_reg  <= jcand_next;
                pcand_reg  <= pcand_next;
                acc_reg    <= acc_next;
                skip_reg   <= skip_next;
                cie_reg    <= cie_next;
                sawff_reg  <= sawff_next;
                count_reg  <= count_next;
            end
        end
    end

    // Result register, loaded from the pre-update state of the byte's pass.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            ostart_reg  <= pstart_reg;
            oend_reg    <= offset_reg + 1'b1;
            ofmt_reg    <= emit_fmt;
            oindex_reg  <= count_reg;
            ostatus_reg <= emit_status;
        end
    end

    assign start_ext = {{OUT_OFFSET_BITS{1'b0}}, ostart_reg};
    assign end_ext   = {{OUT_OFFSET_BITS{1'b0}}, oend_reg};
    assign index_ext = {{OUT_INDEX_BITS{1'b0}}, oindex_reg};

    assign piece_valid  = pvalid_reg;
    assign start_offset = start_ext[OUT_OFFSET_BITS-1:0];
    assign end_offset   = end_ext[OUT_OFFSET_BITS-1:0];
    assign piece_format = ofmt_reg;
    assign piece_index  = index_ext[OUT_INDEX_BITS-1:0];
    assign status       = ostatus_reg;

    // Last byte of a stream returns the parser to a clean start.
    a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_stream) |=> (phase_reg == PH_SIG && offset_reg == '0
                                       && count_reg == '0))
        else $error("parser not restarted after end of stream");

    // Piece count only grows within a stream.
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !end_of_stream) |=> (count_reg >= $past(count_reg)))
        else $error("piece count went backwards");

    // Unrecognized data carries only the trailing or unrecognized status.
    a_other_status: assert property (@(posedge clk) disable iff (!rst_n)
        (pvalid_reg && ofmt_reg == FMT_OTHER) |->
            (ostatus_reg == ST_TRAILING || ostatus_reg == ST_UNRECOG))
        else $error("bad status on unrecognized piece");

    // A stalled result is not overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (pvalid_reg && piece_stall) |=> (pvalid_reg && $stable(oend_reg)
                                         && $stable(ostatus_reg)))
        else $error("held piece item overwritten");

endmodule

`default_nettype wire
